// ===== rtl/core/velocity_cube_trilinear_trace_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the velocity cube trace block
// Shared shorthand for concurrent checks on clocked implications.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_CUBE_TRILINEAR_TRACE_MACROS_SVH
`define VELOCITY_CUBE_TRILINEAR_TRACE_MACROS_SVH

// Same-cycle implication, masked while reset is high
`define VCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is high
`define VCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds through reset
`define VCT_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: reset check failed");

`endif

// ===== rtl/core/vct_pkg.sv =====
// ----------------------------------------------------------------------------
// vct_pkg
// Types, widths and codes shared by the velocity cube trace block.
// ----------------------------------------------------------------------------
`default_nettype none

package vct_pkg;

   localparam int VAL_W     = 32;
   localparam int T_IDX_W   = 8;
   localparam int XY_IDX_W  = 4;
   localparam int LEN_W     = 7;
   localparam int FRAC_W    = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;
   localparam int DIFF_W    = 40;
   localparam int TACC_W    = 39;
   localparam int SLOT_W    = 3;
   localparam int FETCH_W   = 4;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam logic [CSR_W-1:0]  INV_RESET = 32'h0001_0000;
   localparam logic [FETCH_W-1:0] FETCH_LAST = 4'd8;
   localparam logic [SLOT_W-1:0]  BLEND_LAST = 3'd6;

   // opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_TRACE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_ORIGIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_INV    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_ORIGIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_INV       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_ORIGIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_INV       = 3'd5;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_T
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOC_DIFF,
      ST_LOC_MUL,
      ST_LOC_END,
      ST_FETCH,
      ST_BLEND_MUL,
      ST_BLEND_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                req_ready;
      axis_type            loc_axis;
      logic                loc_diff;
      logic                loc_mul;
      logic                loc_end;
      logic [SLOT_W-1:0]   fetch_corner;
      logic                fetch_capture;
      logic [SLOT_W-1:0]   capture_slot;
      logic                blend_mul;
      logic                blend_add;
      logic [SLOT_W-1:0]   blend_step;
      logic                emit;
      logic                advance;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_trace;
      logic req_len_zero;
      logic sample_ok;
      logic last_sample;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/vct_req_if.sv =====
// ----------------------------------------------------------------------------
// vct_req_if
// Request channel: grid loads and trace requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface vct_req_if;
   import vct_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic [T_IDX_W-1:0]        load_time_index;
   logic [XY_IDX_W-1:0]       load_x_index;
   logic [XY_IDX_W-1:0]       load_y_index;
   logic signed [VAL_W-1:0]   load_value;
   logic signed [VAL_W-1:0]   trace_start;
   logic signed [VAL_W-1:0]   trace_step;
   logic [LEN_W-1:0]          trace_length;
   logic signed [VAL_W-1:0]   position_x;
   logic signed [VAL_W-1:0]   position_y;

   modport source (
      output valid, opcode, load_time_index, load_x_index, load_y_index, load_value,
             trace_start, trace_step, trace_length, position_x, position_y,
      input  ready
   );

   modport sink (
      input  valid, opcode, load_time_index, load_x_index, load_y_index, load_value,
             trace_start, trace_step, trace_length, position_x, position_y,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/vct_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vct_rsp_if
// Response channel: one interpolated velocity per trace sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface vct_rsp_if;
   import vct_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] velocity;
   logic                    out_of_range;
   logic                    last_sample;

   modport source (output valid, velocity, out_of_range, last_sample, input ready);
   modport sink   (input valid, velocity, out_of_range, last_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vct_ram.sv =====
// ----------------------------------------------------------------------------
// vct_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vct_ram #(
   parameter int WIDTH      = 32,
   parameter int ADDR_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [2**ADDR_WIDTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== rtl/core/vct_controller.sv =====
// ----------------------------------------------------------------------------
// vct_controller
// Sequencer: locate axes, fetch eight corners, run seven blends, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module vct_controller (
   input  logic                clock,
   input  logic                reset,
   input  vct_pkg::status_type status,
   output vct_pkg::cmd_type    cmd
);
   import vct_pkg::*;

   state_type           state_ff, state_in;
   axis_type            axis_ff, axis_in;
   logic [FETCH_W-1:0]  fetch_ff, fetch_in;
   logic [SLOT_W-1:0]   blend_ff, blend_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= AXIS_X;
         fetch_ff <= '0;
         blend_ff <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         fetch_ff <= fetch_in;
         blend_ff <= blend_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      fetch_in = fetch_ff;
      blend_in = blend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_valid && status.req_is_trace && !status.req_len_zero) begin
               state_in = ST_LOC_DIFF;
               axis_in  = AXIS_X;
            end
         end
         ST_LOC_DIFF: state_in = ST_LOC_MUL;
         ST_LOC_MUL:  state_in = ST_LOC_END;
         ST_LOC_END: begin
            case (axis_ff)
               AXIS_X: begin
                  axis_in  = AXIS_Y;
                  state_in = ST_LOC_DIFF;
               end
               AXIS_Y: begin
                  axis_in  = AXIS_T;
                  state_in = ST_LOC_DIFF;
               end
               default: begin
                  fetch_in = '0;
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_FETCH: begin
            if (!status.sample_ok) begin
               state_in = ST_EMIT;
            end else if (fetch_ff == FETCH_LAST) begin
               blend_in = '0;
               state_in = ST_BLEND_MUL;
            end else begin
               fetch_in = fetch_ff + FETCH_W'(1);
            end
         end
         ST_BLEND_MUL: state_in = ST_BLEND_ADD;
         ST_BLEND_ADD: begin
            if (blend_ff == BLEND_LAST) begin
               state_in = ST_EMIT;
            end else begin
               blend_in = blend_ff + SLOT_W'(1);
               state_in = ST_BLEND_MUL;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (status.last_sample) begin
                  state_in = ST_IDLE;
               end else begin
                  axis_in  = AXIS_T;
                  state_in = ST_LOC_DIFF;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd               = '0;
      cmd.loc_axis      = axis_ff;
      cmd.fetch_corner  = fetch_ff[SLOT_W-1:0];
      cmd.capture_slot  = SLOT_W'(fetch_ff - FETCH_W'(1));
      cmd.blend_step    = blend_ff;
      unique case (state_ff)
         ST_IDLE:      cmd.req_ready = 1'b1;
         ST_LOC_DIFF:  cmd.loc_diff  = 1'b1;
         ST_LOC_MUL:   cmd.loc_mul   = 1'b1;
         ST_LOC_END:   cmd.loc_end   = 1'b1;
         ST_FETCH:     cmd.fetch_capture = status.sample_ok && (fetch_ff != '0);
         ST_BLEND_MUL: cmd.blend_mul = 1'b1;
         ST_BLEND_ADD: cmd.blend_add = 1'b1;
         ST_EMIT: begin
            cmd.emit    = status.out_free;
            cmd.advance = status.out_free && !status.last_sample;
         end
         default: ;
      endcase
   end
endmodule

`default_nettype wire

// ===== rtl/core/vct_datapath.sv =====
// ----------------------------------------------------------------------------
// vct_datapath
// Registers, axis locator, grid memory, corner queue, blend unit, output.
// ----------------------------------------------------------------------------
`default_nettype none

module vct_datapath #(
   parameter int GRID_TIME = 256,
   parameter int GRID_X    = 16,
   parameter int GRID_Y    = 16,
   parameter int MAX_TRACE = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vct_pkg::cmd_type                cmd,
   output vct_pkg::status_type             status,
   vct_req_if.sink                         req,
   vct_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [vct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vct_pkg::CSR_W-1:0]       csr_write_data
);
   import vct_pkg::*;

   localparam int TIW = $clog2(GRID_TIME);
   localparam int XIW = $clog2(GRID_X);
   localparam int YIW = $clog2(GRID_Y);
   localparam int AW  = $clog2(longint'(GRID_TIME) * longint'(GRID_X) * longint'(GRID_Y));

   // configuration registers
   logic signed [VAL_W-1:0] t_origin_ff, x_origin_ff, y_origin_ff;
   logic [CSR_W-1:0]        t_inv_ff, x_inv_ff, y_inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_origin_ff <= '0;
         x_origin_ff <= '0;
         y_origin_ff <= '0;
         t_inv_ff    <= INV_RESET;
         x_inv_ff    <= INV_RESET;
         y_inv_ff    <= INV_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TIME_ORIGIN: t_origin_ff <= csr_write_data;
            CSR_TIME_INV:    t_inv_ff    <= csr_write_data;
            CSR_X_ORIGIN:    x_origin_ff <= csr_write_data;
            CSR_X_INV:       x_inv_ff    <= csr_write_data;
            CSR_Y_ORIGIN:    y_origin_ff <= csr_write_data;
            CSR_Y_INV:       y_inv_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request beat
   logic req_fire;
   assign req.ready = cmd.req_ready;
   assign req_fire  = req.valid && cmd.req_ready;

   // grid load
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [VAL_W-1:0] ram_rdata;
   logic          load_in_grid;

   assign load_in_grid = (int'(req.load_time_index) < GRID_TIME) &&
                         (int'(req.load_x_index) < GRID_X) &&
                         (int'(req.load_y_index) < GRID_Y);
   assign ram_we    = req_fire && (req.opcode == OP_LOAD) && load_in_grid;
   assign ram_waddr = (AW'(req.load_y_index) * AW'(GRID_X) + AW'(req.load_x_index))
                      * AW'(GRID_TIME) + AW'(req.load_time_index);

   // trace request latch
   logic signed [VAL_W-1:0]  step_ff, pos_x_ff, pos_y_ff;
   logic signed [TACC_W-1:0] t_acc_ff;
   logic [LEN_W-1:0]         len_ff, len_in, sample_ff;

   assign len_in = (int'(req.trace_length) > MAX_TRACE) ? LEN_W'(MAX_TRACE)
                                                         : req.trace_length;

   always_ff @(posedge clock) begin
      if (req_fire && (req.opcode == OP_TRACE)) begin
         step_ff   <= req.trace_step;
         pos_x_ff  <= req.position_x;
         pos_y_ff  <= req.position_y;
         len_ff    <= len_in;
         t_acc_ff  <= TACC_W'(req.trace_start);
         sample_ff <= '0;
      end else if (cmd.advance) begin
         t_acc_ff  <= t_acc_ff + TACC_W'(step_ff);
         sample_ff <= sample_ff + LEN_W'(1);
      end
   end

   // axis locator: offset, scale, split into node and fraction
   logic signed [DIFF_W-1:0] coord, origin, diff_ff;
   logic [CSR_W-1:0]         inv;
   logic [DIFF_W-1:0]        node_last;
   logic                     neg_ff;
   logic [54:0]              ph_ff;
   logic [47:0]              pl_ff;
   logic [55:0]              scaled;
   logic [DIFF_W-1:0]        node, node_idx;
   logic [FRAC_W-1:0]        frac;
   logic                     loc_ok, on_last;

   always_comb begin
      case (cmd.loc_axis)
         AXIS_X: begin
            coord     = DIFF_W'(pos_x_ff);
            origin    = DIFF_W'(x_origin_ff);
            inv       = x_inv_ff;
            node_last = DIFF_W'(GRID_X - 1);
         end
         AXIS_Y: begin
            coord     = DIFF_W'(pos_y_ff);
            origin    = DIFF_W'(y_origin_ff);
            inv       = y_inv_ff;
            node_last = DIFF_W'(GRID_Y - 1);
         end
         default: begin
            coord     = DIFF_W'(t_acc_ff);
            origin    = DIFF_W'(t_origin_ff);
            inv       = t_inv_ff;
            node_last = DIFF_W'(GRID_TIME - 1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.loc_diff) begin
         diff_ff <= coord - origin;
      end
      if (cmd.loc_mul) begin
         neg_ff <= diff_ff[DIFF_W-1];
         ph_ff  <= diff_ff[DIFF_W-2:16] * inv;
         pl_ff  <= diff_ff[15:0] * inv;
      end
   end

   assign scaled   = {1'b0, ph_ff} + 56'(pl_ff[47:16]);
   assign node     = scaled[55:16];
   assign on_last  = (node == node_last);
   assign loc_ok   = !neg_ff && ((node < node_last) || (on_last && (scaled[15:0] == '0)));
   assign node_idx = on_last ? (node_last - DIFF_W'(1)) : node;
   assign frac     = on_last ? FRAC_ONE : {1'b0, scaled[15:0]};

   logic [TIW-1:0]    it_ff;
   logic [XIW-1:0]    ix_ff;
   logic [YIW-1:0]    iy_ff;
   logic [FRAC_W-1:0] ft_ff, fx_ff, fy_ff;
   logic              tok_ff, xok_ff, yok_ff;

   // store axis result
   always_ff @(posedge clock) begin
      if (cmd.loc_end) begin
         case (cmd.loc_axis)
            AXIS_X: begin
               ix_ff  <= XIW'(node_idx);
               fx_ff  <= frac;
               xok_ff <= loc_ok;
            end
            AXIS_Y: begin
               iy_ff  <= YIW'(node_idx);
               fy_ff  <= frac;
               yok_ff <= loc_ok;
            end
            default: begin
               it_ff  <= TIW'(node_idx);
               ft_ff  <= frac;
               tok_ff <= loc_ok;
            end
         endcase
      end
   end

   // corner address: bit 0 steps time, bit 1 steps x, bit 2 steps y
   logic [TIW-1:0] t_sel;
   logic [XIW-1:0] x_sel;
   logic [YIW-1:0] y_sel;

   assign t_sel     = it_ff + TIW'(cmd.fetch_corner[0]);
   assign x_sel     = ix_ff + XIW'(cmd.fetch_corner[1]);
   assign y_sel     = iy_ff + YIW'(cmd.fetch_corner[2]);
   assign ram_raddr = (AW'(y_sel) * AW'(GRID_X) + AW'(x_sel)) * AW'(GRID_TIME) + AW'(t_sel);

   vct_ram #(
      .WIDTH      (VAL_W),
      .ADDR_WIDTH (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req.load_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // blend unit: a + (b - a) * f, round half up
   logic signed [VAL_W-1:0]  q_ff [8];
   logic signed [VAL_W-1:0]  a_blend_ff, blend_res;
   logic signed [VAL_W:0]    blend_diff;
   logic signed [50:0]       prod_ff;
   logic signed [51:0]       a_ext, blend_sum;
   logic [FRAC_W-1:0]        f_sel;

   always_comb begin
      if (cmd.blend_step < SLOT_W'(4)) begin
         f_sel = ft_ff;
      end else if (cmd.blend_step < BLEND_LAST) begin
         f_sel = fx_ff;
      end else begin
         f_sel = fy_ff;
      end
   end

   assign blend_diff = {q_ff[1][VAL_W-1], q_ff[1]} - {q_ff[0][VAL_W-1], q_ff[0]};
   assign a_ext      = {{4{a_blend_ff[VAL_W-1]}}, a_blend_ff, 16'h0000};
   assign blend_sum  = a_ext + 52'(prod_ff) + 52'sh8000;
   assign blend_res  = blend_sum[47:16];

   always_ff @(posedge clock) begin
      if (cmd.blend_mul) begin
         prod_ff    <= blend_diff * $signed({1'b0, f_sel});
         a_blend_ff <= q_ff[0];
      end
   end

   // corner queue: fill from memory, pop two and push one per blend
   always_ff @(posedge clock) begin
      if (cmd.fetch_capture) begin
         q_ff[cmd.capture_slot] <= ram_rdata;
      end else if (cmd.blend_add) begin
         for (int i = 0; i < 6; i++) begin
            q_ff[i] <= q_ff[i+2];
         end
         q_ff[SLOT_W'(BLEND_LAST - cmd.blend_step)] <= blend_res;
      end
   end

   // output register
   logic                    rsp_valid_ff, rsp_oor_ff, rsp_last_ff;
   logic signed [VAL_W-1:0] rsp_vel_ff;
   logic                    sample_ok, last_sample;

   assign sample_ok   = xok_ff && yok_ff && tok_ff;
   assign last_sample = ((sample_ff + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_vel_ff  <= sample_ok ? q_ff[0] : '0;
         rsp_oor_ff  <= !sample_ok;
         rsp_last_ff <= last_sample;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.velocity     = rsp_vel_ff;
   assign rsp.out_of_range = rsp_oor_ff;
   assign rsp.last_sample  = rsp_last_ff;

   // status to the sequencer
   assign status.req_valid    = req.valid;
   assign status.req_is_trace = (req.opcode == OP_TRACE);
   assign status.req_len_zero = (req.trace_length == '0);
   assign status.sample_ok    = sample_ok;
   assign status.last_sample  = last_sample;
   assign status.out_free     = !rsp_valid_ff || rsp.ready;
endmodule

`default_nettype wire

// ===== rtl/core/velocity_cube_trilinear_trace.sv =====
// ----------------------------------------------------------------------------
// velocity_cube_trilinear_trace
// 3-D velocity grid with trilinear interpolation along a time trace.
// ----------------------------------------------------------------------------
//  channel      dir   handshake       payload
//  req_channel  in    valid/ready     opcode, load fields, trace fields
//  rsp_channel  out   valid/ready     velocity, out_of_range, last_sample
//  csr_*        in    write enable    index, 32-bit data
//
//  A trace request locates x and y, then for each sample locates time. An
//  in-range sample then takes eight corner reads on the single grid read
//  port and seven passes of the shared blend unit before its emit; an
//  out-of-range sample goes straight to emit.
//  Reset clears control and configuration; the grid keeps its contents.
//  A stalled response holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_cube_trilinear_trace #(
   parameter int GRID_TIME = 256,
   parameter int GRID_X    = 16,
   parameter int GRID_Y    = 16,
   parameter int MAX_TRACE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   vct_req_if.sink                       req_channel,
   vct_rsp_if.source                     rsp_channel,
   input  logic                          csr_write_enable,
   input  logic [vct_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vct_pkg::CSR_W-1:0]     csr_write_data
);
   import vct_pkg::*;

   cmd_type    cmd;
   status_type status;

   vct_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   vct_datapath #(
      .GRID_TIME (GRID_TIME),
      .GRID_X    (GRID_X),
      .GRID_Y    (GRID_Y),
      .MAX_TRACE (MAX_TRACE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req              (req_channel),
      .rsp              (rsp_channel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );
endmodule

`default_nettype wire

// ===== rtl/core/vct_checker.sv =====
// ----------------------------------------------------------------------------
// vct_checker
// Port-level checks on the velocity cube trace block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "velocity_cube_trilinear_trace_macros.svh"

module vct_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [vct_pkg::VAL_W-1:0]   rsp_velocity,
   input logic                               rsp_out_of_range,
   input logic                               rsp_last_sample
);
   import vct_pkg::*;

   // a stalled response beat stays valid and holds its velocity and last-sample flag
   `VCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_velocity) && $stable(rsp_last_sample))

   // an out-of-range sample carries zero velocity
   `VCT_ASSERT_IMP(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_velocity == '0)

   // no new request while a trace still has samples to come
   `VCT_ASSERT_IMP(a_busy_mid_trace, clock, reset, rsp_valid && !rsp_last_sample, !req_ready)

   // reset drops any pending response
   `VCT_ASSERT_NXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)
endmodule

bind velocity_cube_trilinear_trace vct_checker u_vct_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_channel.ready),
   .rsp_valid        (rsp_channel.valid),
   .rsp_ready        (rsp_channel.ready),
   .rsp_velocity     (rsp_channel.velocity),
   .rsp_out_of_range (rsp_channel.out_of_range),
   .rsp_last_sample  (rsp_channel.last_sample)
);

`default_nettype wire
